### rtl/multichannel_servo_pwm_core_assert.svh
// assertion macros for the servo pwm core checker
// no dependencies; included by the checker file
`ifndef MULTICHANNEL_SERVO_PWM_CORE_ASSERT_SVH
`define MULTICHANNEL_SERVO_PWM_CORE_ASSERT_SVH

// checked only outside reset
`define MSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// checked on every edge, reset included
`define MSP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

### rtl/msp_pkg.sv
// shared types and constants for the servo pwm core
// no dependencies
package msp_pkg;

   localparam int FUNC_W      = 2;
   localparam int CHAN_W      = 5;
   localparam int WIDTH_US_W  = 16;
   localparam int PINS_W      = 18;
   localparam int COUNT_W     = 32;
   localparam int PERIOD_W    = 24;
   localparam int RATE_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;
   localparam int PROD_W      = WIDTH_US_W + RATE_W;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd420000;
   localparam logic [RATE_W-1:0]   RATE_RESET   = 8'd42;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_SET_WIDTH = 2'd1,
      FUNC_START     = 2'd2,
      FUNC_STOP      = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PERIOD_TICKS = 1'd0,
      CSR_TICKS_PER_US = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic tick;
      logic period_end;
      logic compare_en;
   } timer_status_type;

endpackage

### rtl/msp_if.sv
// request and response channel interfaces for the servo pwm core
// depends on msp_pkg
interface msp_req_if
   import msp_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [CHAN_W-1:0]     channel;
   logic [WIDTH_US_W-1:0] width_us;

   modport source (output valid, output func, output channel, output width_us, input ready);
   modport sink   (input valid, input func, input channel, input width_us, output ready);
endinterface

interface msp_rsp_if
   import msp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PINS_W-1:0]  pins;
   logic [COUNT_W-1:0] period_count;
   logic               period_start;

   modport source (output valid, output pins, output period_count, output period_start,
                   input ready);
   modport sink   (input valid, input pins, input period_count, input period_start,
                   output ready);
endinterface

### rtl/msp_timer.sv
// shared period timer, period counter and run/enable control
// depends on msp_pkg
module msp_timer
   import msp_pkg::*;
#(
   parameter int TICK_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  func_type              func,
   input  logic [PERIOD_W-1:0]   period_ticks,
   output timer_status_type      status,
   output logic [TICK_BITS-1:0]  elapsed,
   output logic [COUNT_W-1:0]    periods
);

   localparam int CMP_W = (TICK_BITS >= PERIOD_W) ? TICK_BITS + 1 : PERIOD_W;

   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [COUNT_W-1:0]   periods_ff, periods_in;
   logic                 running_ff, running_in;
   logic                 enabled_ff, enabled_in;
   logic [TICK_BITS:0]   tick_inc;
   logic                 is_tick;
   logic                 wrap;
   logic                 period_end;

   assign tick_inc   = {1'b0, tick_ff} + {{TICK_BITS{1'b0}}, 1'b1};
   assign is_tick    = go && (func == FUNC_TICK) && running_ff;
   assign wrap       = (CMP_W'(tick_inc) >= CMP_W'(period_ticks)) || tick_inc[TICK_BITS];
   assign period_end = is_tick && wrap;

   always_comb begin
      tick_in    = tick_ff;
      periods_in = periods_ff;
      running_in = running_ff;
      enabled_in = enabled_ff;
      if (go) begin
         unique case (func)
            FUNC_TICK: begin
               if (running_ff) begin
                  tick_in = wrap ? '0 : tick_inc[TICK_BITS-1:0];
                  if (wrap) begin
                     periods_in = periods_ff + 32'd1;
                     enabled_in = 1'b1;
                  end
               end
            end
            FUNC_SET_WIDTH: begin
            end
            FUNC_START: begin
               running_in = 1'b1;
               tick_in    = '0;
               periods_in = '0;
            end
            FUNC_STOP: begin
               running_in = 1'b0;
               enabled_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         periods_ff <= '0;
         running_ff <= 1'b0;
         enabled_ff <= 1'b0;
      end else begin
         tick_ff    <= tick_in;
         periods_ff <= periods_in;
         running_ff <= running_in;
         enabled_ff <= enabled_in;
      end
   end

   assign status.tick       = is_tick;
   assign status.period_end = period_end;
   assign status.compare_en = enabled_ff || period_end;
   assign elapsed           = tick_in;
   assign periods           = periods_in;

endmodule

### rtl/msp_bank.sv
// channel bank: width conversion, shadow and active compares, pin levels
// depends on msp_pkg
module msp_bank
   import msp_pkg::*;
#(
   parameter int CHANNELS  = 18,
   parameter int TICK_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  set_width,
   input  logic [CHAN_W-1:0]     channel,
   input  logic [WIDTH_US_W-1:0] width_us,
   input  logic [RATE_W-1:0]     ticks_per_us,
   input  timer_status_type      status,
   input  logic [TICK_BITS-1:0]  elapsed,
   output logic [PINS_W-1:0]     pins
);

   localparam int SAT_W = (TICK_BITS > PROD_W) ? TICK_BITS + 1 : PROD_W + 1;
   localparam logic [SAT_W-1:0] TICK_MAX = SAT_W'((65'd1 << TICK_BITS) - 65'd1);

   logic [TICK_BITS-1:0] shadow_ff [CHANNELS];
   logic [TICK_BITS-1:0] active_ff [CHANNELS];
   logic [CHANNELS-1:0]  pins_ff, pins_in;
   logic [PROD_W-1:0]    product;
   logic [SAT_W-1:0]     wide;
   logic [SAT_W-1:0]     sat;
   logic [TICK_BITS-1:0] ticks;
   logic [CHANNELS-1:0]  hit;

   assign product = PROD_W'(width_us) * PROD_W'(ticks_per_us);
   assign wide    = SAT_W'(product);
   assign sat     = (wide > TICK_MAX) ? TICK_MAX : wide;
   assign ticks   = sat[TICK_BITS-1:0];

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      logic [TICK_BITS-1:0] cmp_width;
      assign cmp_width = status.period_end ? shadow_ff[i] : active_ff[i];
      assign hit[i]    = status.compare_en && (cmp_width == elapsed);

      always_ff @(posedge clock) begin
         if (reset) begin
            shadow_ff[i] <= '0;
            active_ff[i] <= '0;
         end else begin
            if (set_width && (7'(channel) == 7'(i)))
               shadow_ff[i] <= ticks;
            if (status.period_end)
               active_ff[i] <= shadow_ff[i];
         end
      end
   end

   always_comb begin
      pins_in = pins_ff;
      if (status.tick) begin
         if (status.period_end)
            pins_in = '1;
         pins_in = pins_in & ~hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         pins_ff <= '1;
      else
         pins_ff <= pins_in;
   end

   for (genvar p = 0; p < PINS_W; p++) begin : g_pin
      if (p < CHANNELS) begin : g_used
         assign pins[p] = pins_in[p];
      end else begin : g_unused
         assign pins[p] = 1'b0;
      end
   end

endmodule

### rtl/multichannel_servo_pwm_core.sv
// top level of the multichannel servo pwm core
// depends on msp_pkg, msp_if, msp_timer and msp_bank
//
//   channel | direction | contents
//   req     | in        | func, channel, width_us
//   rsp     | out       | pins, period_count, period_start
//   csr     | in        | period_ticks, ticks_per_us (write only)
//
// one word per cycle while the response is not stalled; a request passes through
// the input register, then channel compares and timer update into the response register
// synchronous reset; pins come up high
// a stalled response holds the input register; req ready is high when the input register is empty or rsp can advance
module multichannel_servo_pwm_core
   import msp_pkg::*;
#(
   parameter int CHANNELS  = 18,
   parameter int TICK_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   msp_req_if.sink                req_chan,
   msp_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [PERIOD_W-1:0]   period_ff;
   logic [RATE_W-1:0]     rate_ff;

   logic                  in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [CHAN_W-1:0]     channel_ff;
   logic [WIDTH_US_W-1:0] width_us_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PINS_W-1:0]     rsp_pins_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_start_ff;

   logic                  out_adv;
   logic                  go;
   logic                  req_take;
   func_type              func;
   timer_status_type      status;
   logic [TICK_BITS-1:0]  elapsed;
   logic [COUNT_W-1:0]    periods;
   logic [PINS_W-1:0]     pins;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         rate_ff   <= RATE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PERIOD_TICKS: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_TICKS_PER_US: rate_ff   <= csr_wdata[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_adv        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || out_adv;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign go             = in_valid_ff && out_adv;
   assign func           = func_type'(func_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (out_adv)
         in_valid_in = 1'b0;
      rsp_valid_in = out_adv ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff     <= req_chan.func;
         channel_ff  <= req_chan.channel;
         width_us_ff <= req_chan.width_us;
      end
      if (go) begin
         rsp_pins_ff  <= pins;
         rsp_count_ff <= periods;
         rsp_start_ff <= status.period_end;
      end
   end

   msp_timer #(
      .TICK_BITS (TICK_BITS)
   ) u_timer (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .func         (func),
      .period_ticks (period_ff),
      .status       (status),
      .elapsed      (elapsed),
      .periods      (periods)
   );

   msp_bank #(
      .CHANNELS  (CHANNELS),
      .TICK_BITS (TICK_BITS)
   ) u_bank (
      .clock        (clock),
      .reset        (reset),
      .set_width    (go && (func == FUNC_SET_WIDTH)),
      .channel      (channel_ff),
      .width_us     (width_us_ff),
      .ticks_per_us (rate_ff),
      .status       (status),
      .elapsed      (elapsed),
      .pins         (pins)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pins         = rsp_pins_ff;
   assign rsp_chan.period_count = rsp_count_ff;
   assign rsp_chan.period_start = rsp_start_ff;

endmodule

### rtl/msp_checker.sv
// port-level checks for the servo pwm core, bound to the top level
// depends on msp_pkg and multichannel_servo_pwm_core_assert.svh
`include "multichannel_servo_pwm_core_assert.svh"

module msp_checker
   import msp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PINS_W-1:0]  rsp_pins,
   input logic [COUNT_W-1:0] rsp_period_count,
   input logic               rsp_period_start
);

   // an empty response register never blocks requests
   `MSP_ASSERT_ALWAYS(a_empty_out_ready, clock, !rsp_valid |-> req_ready)

   // reset empties the response register
   `MSP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

   // an idle request channel with an empty response register, held over a clock edge, leaves nothing in flight
   `MSP_ASSERT(a_two_cycle_path, clock, reset,
      !rsp_valid && !req_valid ##1 !rsp_valid && !req_valid |=> !rsp_valid)

   // stalled response word holds
   `MSP_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pins) &&
         $stable(rsp_period_count) && $stable(rsp_period_start))

endmodule

bind multichannel_servo_pwm_core msp_checker u_msp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pins         (rsp_chan.pins),
   .rsp_period_count (rsp_chan.period_count),
   .rsp_period_start (rsp_chan.period_start)
);

### tb/multichannel_servo_pwm_core_test.sv
// self-checking test of the multichannel servo pwm core: directed words, then random runs
// under several period and rate settings, with idling and a long response hold-off
// depends on msp_pkg, msp_if and multichannel_servo_pwm_core
module multichannel_servo_pwm_core_test;
   import msp_pkg::*;

   localparam int CHANNELS    = 18;
   localparam int TICK_BITS   = 24;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [PINS_W-1:0]  pins;
      logic [COUNT_W-1:0] period_count;
      logic               period_start;
   } pwm_word_t;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   msp_req_if req_chan ();
   msp_rsp_if rsp_chan ();

   multichannel_servo_pwm_core #(
      .CHANNELS  (CHANNELS),
      .TICK_BITS (TICK_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted state of the pwm generator
   logic [PERIOD_W-1:0]  cfg_period    = PERIOD_RESET;
   logic [RATE_W-1:0]    cfg_rate      = RATE_RESET;
   logic [TICK_BITS-1:0] elapsed_ticks = '0;
   logic [COUNT_W-1:0]   period_total  = '0;
   logic [TICK_BITS-1:0] staged_width [CHANNELS] = '{default: '0};
   logic [TICK_BITS-1:0] live_width [CHANNELS]   = '{default: '0};
   logic [PINS_W-1:0]    pin_state     = '1;
   logic                 timer_on      = 1'b0;
   logic                 compare_on    = 1'b0;

   pwm_word_t   awaited_words [$];
   int unsigned mismatches  = 0;
   int unsigned holdoff_len = 0;
   int unsigned cycles      = 0;
   bit          gaps_on     = 1'b1;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic pwm_word_t predict_pwm_word(input func_type f,
                                                  input logic [CHAN_W-1:0] ch,
                                                  input logic [WIDTH_US_W-1:0] us);
      logic [TICK_BITS:0] next_tick;
      logic [31:0]        product;
      pwm_word_t          word;
      word.period_start = 1'b0;
      case (f)
         FUNC_TICK: begin
            if (timer_on) begin
               next_tick = {1'b0, elapsed_ticks} + 1'b1;
               if (next_tick >= {1'b0, cfg_period} ||
                   next_tick > {1'b0, {TICK_BITS{1'b1}}}) begin
                  next_tick         = '0;
                  period_total      = period_total + 1'b1;
                  pin_state         = '1;
                  live_width        = staged_width;
                  compare_on        = 1'b1;
                  word.period_start = 1'b1;
               end
               elapsed_ticks = next_tick[TICK_BITS-1:0];
               if (compare_on) begin
                  for (int i = 0; i < CHANNELS; i++)
                     if (live_width[i] == elapsed_ticks) pin_state[i] = 1'b0;
               end
            end
         end
         FUNC_SET_WIDTH: begin
            if (ch < CHANNELS) begin
               product = 32'(us) * 32'(cfg_rate);
               staged_width[ch] = (product > {TICK_BITS{1'b1}}) ? '1 : product[TICK_BITS-1:0];
            end
         end
         FUNC_START: begin
            timer_on      = 1'b1;
            elapsed_ticks = '0;
            period_total  = '0;
         end
         default: begin
            timer_on   = 1'b0;
            compare_on = 1'b0;
         end
      endcase
      word.pins         = pin_state;
      word.period_count = period_total;
      return word;
   endfunction

   task automatic report_mismatch(input string text);
      $display("%0t: %s", $time, text);
      mismatches++;
   endtask

   // handshakes are sampled at the falling edge, where every signal is settled
   always @(negedge clock) begin : watch_words
      pwm_word_t want;
      if (reset === 1'b0) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (awaited_words.size() == 0) begin
               report_mismatch("response word with none expected");
            end else begin
               want = awaited_words.pop_front();
               if (rsp_chan.pins !== want.pins)
                  report_mismatch($sformatf("pins %h, expected %h", rsp_chan.pins, want.pins));
               if (rsp_chan.period_count !== want.period_count)
                  report_mismatch($sformatf("period_count %0d, expected %0d",
                                            rsp_chan.period_count, want.period_count));
               if (rsp_chan.period_start !== want.period_start)
                  report_mismatch($sformatf("period_start %b, expected %b",
                                            rsp_chan.period_start, want.period_start));
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            awaited_words.push_back(predict_pwm_word(func_type'(req_chan.func),
                                                     req_chan.channel, req_chan.width_us));
      end
   end

   initial begin : response_sink
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall = 0;
         if (holdoff_len != 0) begin
            stall       = holdoff_len;
            holdoff_len = 0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 13);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_word(input func_type f, input logic [CHAN_W-1:0] ch,
                            input logic [WIDTH_US_W-1:0] us);
      int unsigned gap;
      if (gaps_on && $urandom_range(0, 6) == 0) begin
         gap = $urandom_range(1, 13);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.func     <= f;
      req_chan.channel  <= ch;
      req_chan.width_us <= us;
      do @(negedge clock); while (req_chan.ready !== 1'b1);
      @(posedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PERIOD_TICKS: cfg_period = value[PERIOD_W-1:0];
         default:          cfg_rate   = value[RATE_W-1:0];
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [PERIOD_W-1:0] period, input logic [RATE_W-1:0] rate);
      settle();
      write_register(CSR_PERIOD_TICKS, period);
      // upper bits of the rate word are not part of the register
      write_register(CSR_TICKS_PER_US, {16'($urandom), rate});
   endtask

   task automatic send_random_word();
      int unsigned         pick;
      int unsigned         span;
      logic [CHAN_W-1:0]   ch;
      logic [WIDTH_US_W-1:0] us;
      pick = $urandom_range(0, 99);
      ch   = CHAN_W'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 9) == 0) ch = CHAN_W'($urandom_range(CHANNELS, 31));
      span = (cfg_rate == 0) ? 65535 : cfg_period / cfg_rate + 1;
      if (span > 65535) span = 65535;
      case ($urandom_range(0, 9))
         7, 8:    us = 16'($urandom);
         9:       us = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: us = WIDTH_US_W'($urandom_range(0, span));
      endcase
      if (pick < 5)       send_word(FUNC_START, ch, us);
      else if (pick < 7)  send_word(FUNC_STOP, ch, us);
      else if (pick < 25) send_word(FUNC_SET_WIDTH, ch, us);
      else                send_word(FUNC_TICK, ch, us);
   endtask

   task automatic test_reset_defaults();
      send_word(FUNC_TICK, 5'd0, 16'd0);
      send_word(FUNC_SET_WIDTH, 5'd1, 16'd1500);
      send_word(FUNC_START, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
   endtask

   task automatic test_directed_extremes();
      set_timing(24'd4, 8'd1);
      send_word(FUNC_SET_WIDTH, 5'd0, 16'd0);
      send_word(FUNC_SET_WIDTH, 5'd17, 16'hFFFF);
      send_word(FUNC_SET_WIDTH, 5'd18, 16'd3);
      send_word(FUNC_SET_WIDTH, 5'd31, 16'hFFFF);
      send_word(FUNC_SET_WIDTH, 5'd5, 16'd2);
      send_word(FUNC_START, 5'd0, 16'd0);
      // compares stay off until the first period end
      repeat (6) send_word(FUNC_TICK, 5'd0, 16'd0);
      // restart while running
      send_word(FUNC_START, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
      send_word(FUNC_STOP, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
   endtask

   task automatic test_zero_settings();
      set_timing(24'd0, 8'd0);
      send_word(FUNC_SET_WIDTH, 5'd3, 16'd777);
      send_word(FUNC_START, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
   endtask

   task automatic test_largest_settings();
      set_timing(24'hFFFFFF, 8'hFF);
      send_word(FUNC_SET_WIDTH, 5'd9, 16'hFFFF);
      send_word(FUNC_START, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
      send_word(FUNC_TICK, 5'd0, 16'd0);
   endtask

   task automatic test_random_phases();
      set_timing(24'd20, 8'd1);
      repeat (90) send_random_word();
      set_timing(24'd1, 8'd1);
      repeat (60) send_random_word();
      set_timing(24'd50, 8'd4);
      repeat (90) send_random_word();
      set_timing(24'd600, 8'd255);
      repeat (40) send_random_word();
      set_timing(24'd7, 8'd2);
      repeat (90) send_random_word();
      set_timing(24'($urandom_range(2, 80)), 8'($urandom_range(1, 255)));
      repeat (90) send_random_word();
      set_timing(24'hFFFFFF, 8'd1);
      repeat (20) send_random_word();
   endtask

   task automatic test_output_backpressure();
      set_timing(24'd12, 8'd1);
      send_word(FUNC_START, 5'd0, 16'd0);
      holdoff_len = 90;
      repeat (50) send_random_word();
   endtask

   task automatic test_ungapped_run();
      set_timing(24'd9, 8'd2);
      gaps_on = 1'b0;
      send_word(FUNC_START, 5'd0, 16'd0);
      repeat (80) send_random_word();
   endtask

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_PERIOD_TICKS;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.func     <= FUNC_TICK;
      req_chan.channel  <= '0;
      req_chan.width_us <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_extremes();
      test_zero_settings();
      test_largest_settings();
      test_random_phases();
      test_output_backpressure();
      test_ungapped_run();
      settle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
